FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the multiply/divide unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_IMP_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/imdu_pkg.sv
// Shared types and constants of the integer multiply/divide unit.
package imdu_pkg;

  localparam int XLEN = 64;
  localparam int HALF = 32;
  localparam int OP_W = 4;
  localparam int DIV_STAGES = 64;
  localparam int MUL_STAGES = 3;
  localparam int MUL_DLY = DIV_STAGES - MUL_STAGES;

  localparam logic [OP_W-1:0] OP_UMADDL = 4'd0;
  localparam logic [OP_W-1:0] OP_UMSUBL = 4'd1;
  localparam logic [OP_W-1:0] OP_SMADDL = 4'd2;
  localparam logic [OP_W-1:0] OP_SMSUBL = 4'd3;
  localparam logic [OP_W-1:0] OP_MADD   = 4'd4;
  localparam logic [OP_W-1:0] OP_MSUB   = 4'd5;
  localparam logic [OP_W-1:0] OP_SMULH  = 4'd6;
  localparam logic [OP_W-1:0] OP_UMULH  = 4'd7;
  localparam logic [OP_W-1:0] OP_UDIV   = 4'd8;
  localparam logic [OP_W-1:0] OP_SDIV   = 4'd9;

  // Control that rides along the divider chain with each request.
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic            wide;
    logic            qneg;
    logic            dz;
  } imdu_ctl_t;

endpackage

FILE: rtl/core/imdu_div_cell.sv
// One restoring-division step: a quotient bit per cell.
`include "assert_macros.svh"

module imdu_div_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  imdu_pkg::imdu_ctl_t     ctl_in,
  input  logic [imdu_pkg::XLEN-1:0] rem_in,
  input  logic [imdu_pkg::XLEN-1:0] num_in,
  input  logic [imdu_pkg::XLEN-1:0] den_in,
  output imdu_pkg::imdu_ctl_t     ctl_out,
  output logic [imdu_pkg::XLEN-1:0] rem_out,
  output logic [imdu_pkg::XLEN-1:0] num_out,
  output logic [imdu_pkg::XLEN-1:0] den_out
);

  logic [imdu_pkg::XLEN:0]   trial;
  logic [imdu_pkg::XLEN:0]   shifted;
  logic                      qbit;
  logic [imdu_pkg::XLEN-1:0] rem_next;

  assign shifted  = {rem_in, num_in[imdu_pkg::XLEN-1]};
  assign trial    = shifted - {1'b0, den_in};
  assign qbit     = ~trial[imdu_pkg::XLEN];
  assign rem_next = qbit ? trial[imdu_pkg::XLEN-1:0] : shifted[imdu_pkg::XLEN-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.op   <= ctl_in.op;
    ctl_out.wide <= ctl_in.wide;
    ctl_out.qneg <= ctl_in.qneg;
    ctl_out.dz   <= ctl_in.dz;
    rem_out      <= rem_next;
    num_out      <= {num_in[imdu_pkg::XLEN-2:0], qbit};
    den_out      <= den_in;
  end

  // partial remainder always stays below a nonzero divisor
  `ASSERT_IMP(a_rem_below_den, clk, rst, ctl_out.valid && !ctl_out.dz, rem_out < den_out)

endmodule

FILE: rtl/core/imdu_mul.sv
// Three-stage 64x64 multiplier with accumulate and high-half forms.
module imdu_mul (
  input  logic                          clk,
  input  logic [imdu_pkg::OP_W-1:0]     op,
  input  logic                          wide,
  input  logic [imdu_pkg::XLEN-1:0]     x,
  input  logic [imdu_pkg::XLEN-1:0]     y,
  input  logic [imdu_pkg::XLEN-1:0]     acc,
  output logic [imdu_pkg::XLEN-1:0]     prod_res
);

  localparam int H = imdu_pkg::HALF;
  localparam int W = imdu_pkg::XLEN;

  // stage 1: partial products
  logic [W-1:0] ll, lh, hl, hh;
  logic [W-1:0] x1, y1, acc1;
  logic [imdu_pkg::OP_W-1:0] op1;
  logic wide1;
  // stage 2: full product
  logic [2*W-1:0] prod2;
  logic [W-1:0] x2, y2, acc2;
  logic [imdu_pkg::OP_W-1:0] op2;
  logic wide2;

  logic [2*W-1:0] sum_next;
  logic [W-1:0]   lo, hi_u, hi_s, r_next;

  always_ff @(posedge clk) begin
    ll    <= x[H-1:0] * y[H-1:0];
    lh    <= x[H-1:0] * y[W-1:H];
    hl    <= x[W-1:H] * y[H-1:0];
    hh    <= x[W-1:H] * y[W-1:H];
    x1    <= x;
    y1    <= y;
    acc1  <= acc;
    op1   <= op;
    wide1 <= wide;
  end

  assign sum_next = {{W{1'b0}}, ll} + {{H{1'b0}}, lh, {H{1'b0}}}
                  + {{H{1'b0}}, hl, {H{1'b0}}} + {hh, {W{1'b0}}};

  always_ff @(posedge clk) begin
    prod2 <= sum_next;
    x2    <= x1;
    y2    <= y1;
    acc2  <= acc1;
    op2   <= op1;
    wide2 <= wide1;
  end

  assign lo   = prod2[W-1:0];
  assign hi_u = prod2[2*W-1:W];
  assign hi_s = hi_u - (x2[W-1] ? y2 : '0) - (y2[W-1] ? x2 : '0);

  always_comb begin
    case (op2)
      imdu_pkg::OP_UMADDL, imdu_pkg::OP_SMADDL: r_next = acc2 + lo;
      imdu_pkg::OP_UMSUBL, imdu_pkg::OP_SMSUBL: r_next = acc2 - lo;
      imdu_pkg::OP_MADD: r_next = wide2 ? (acc2 + lo)
                                        : {{H{1'b0}}, acc2[H-1:0] + lo[H-1:0]};
      imdu_pkg::OP_MSUB: r_next = wide2 ? (acc2 - lo)
                                        : {{H{1'b0}}, acc2[H-1:0] - lo[H-1:0]};
      imdu_pkg::OP_SMULH: r_next = hi_s;
      imdu_pkg::OP_UMULH: r_next = hi_u;
      default: r_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_res <= r_next;
  end

endmodule

FILE: rtl/core/integer_multiply_divide_unit.sv
// Top level of the integer multiply/divide unit.
//
//  channel   handshake            payload
//  request   start (busy = 0)     opcode, is_64bit, src_a, src_b, src_acc
//  result    done (one cycle)     result
//
// Every opcode takes the same path through the unit: one
// operand-prep stage, a chain of 64 division cells (one quotient bit each),
// and one result stage. The multiplier (3 stages) runs beside the chain and
// its result waits in a delay line so results leave in request order.
// A new request is taken every cycle; busy is always low.
// Synchronous active-high rst clears all valid bits; data regs are not reset.
// The receiver cannot stall: done marks a result for exactly one cycle.
`include "assert_macros.svh"

module integer_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  opcode,
  input  logic        is_64bit,
  input  logic [63:0] src_a,
  input  logic [63:0] src_b,
  input  logic [63:0] src_acc,
  output logic        done,
  output logic [63:0] result
);

  localparam int W = imdu_pkg::XLEN;
  localparam int H = imdu_pkg::HALF;
  localparam int N = imdu_pkg::DIV_STAGES;
  localparam int D = imdu_pkg::MUL_DLY;

  assign busy = 1'b0;

  // ---- operand prep ----
  logic [W-1:0] a_s32, b_s32, a_z32, b_z32;
  logic [W-1:0] sa, sb, dn_next, dd_next, mx_next, my_next;
  logic         qneg_next;

  assign a_s32 = {{H{src_a[H-1]}}, src_a[H-1:0]};
  assign b_s32 = {{H{src_b[H-1]}}, src_b[H-1:0]};
  assign a_z32 = {{H{1'b0}}, src_a[H-1:0]};
  assign b_z32 = {{H{1'b0}}, src_b[H-1:0]};
  assign sa    = is_64bit ? src_a : a_s32;
  assign sb    = is_64bit ? src_b : b_s32;

  always_comb begin
    qneg_next = 1'b0;
    dn_next   = is_64bit ? src_a : a_z32;
    dd_next   = is_64bit ? src_b : b_z32;
    if (opcode == imdu_pkg::OP_SDIV) begin
      dn_next   = sa[W-1] ? (W'(0) - sa) : sa;
      dd_next   = sb[W-1] ? (W'(0) - sb) : sb;
      qneg_next = sa[W-1] ^ sb[W-1];
    end
  end

  always_comb begin
    case (opcode)
      imdu_pkg::OP_UMADDL, imdu_pkg::OP_UMSUBL: begin
        mx_next = a_z32;
        my_next = b_z32;
      end
      imdu_pkg::OP_SMADDL, imdu_pkg::OP_SMSUBL: begin
        mx_next = a_s32;
        my_next = b_s32;
      end
      default: begin
        mx_next = src_a;
        my_next = src_b;
      end
    endcase
  end

  imdu_pkg::imdu_ctl_t ctl [0:N];
  logic [W-1:0] rem [0:N];
  logic [W-1:0] num [0:N];
  logic [W-1:0] den [0:N];
  logic [W-1:0] mx, my, macc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= start;
    end
    ctl[0].op   <= opcode;
    ctl[0].wide <= is_64bit;
    ctl[0].qneg <= qneg_next;
    ctl[0].dz   <= (dd_next == '0);
    rem[0]      <= '0;
    num[0]      <= dn_next;
    den[0]      <= dd_next;
    mx          <= mx_next;
    my          <= my_next;
    macc        <= src_acc;
  end

  // ---- division chain ----
  for (genvar i = 0; i < N; i++) begin : g_cell
    imdu_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl[i]),
      .rem_in  (rem[i]),
      .num_in  (num[i]),
      .den_in  (den[i]),
      .ctl_out (ctl[i+1]),
      .rem_out (rem[i+1]),
      .num_out (num[i+1]),
      .den_out (den[i+1])
    );
  end

  // ---- multiplier and its delay line ----
  logic [W-1:0] mul_res;
  logic [W-1:0] mul_dly [0:D-1];

  imdu_mul u_mul (
    .clk      (clk),
    .op       (ctl[0].op),
    .wide     (ctl[0].wide),
    .x        (mx),
    .y        (my),
    .acc      (macc),
    .prod_res (mul_res)
  );

  always_ff @(posedge clk) begin
    mul_dly[0] <= mul_res;
    for (int k = 1; k < D; k++) begin
      mul_dly[k] <= mul_dly[k-1];
    end
  end

  // ---- result stage ----
  imdu_pkg::imdu_ctl_t fc;
  logic [W-1:0] q_sgn, res_next;

  assign fc    = ctl[N];
  assign q_sgn = fc.qneg ? (W'(0) - num[N]) : num[N];

  always_comb begin
    if (fc.op inside {imdu_pkg::OP_UDIV, imdu_pkg::OP_SDIV}) begin
      if (fc.dz) begin
        res_next = '0;
      end else if (fc.wide) begin
        res_next = q_sgn;
      end else begin
        res_next = {{H{1'b0}}, q_sgn[H-1:0]};
      end
    end else begin
      res_next = mul_dly[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fc.valid;
    end
    result <= res_next;
  end

  `ASSERT_IMP(a_done_has_request, clk, rst, done, $past(start, N + 2))
  `ASSERT_IMP_NEXT(a_request_completes, clk, rst, start, ##(N + 1) done)

endmodule
